FILE: rtl/fhls_pkg.sv
// ----------------------------------------------------------------------------
// fhls_pkg
// shared constants and types for the frame history luma scratcher
// ----------------------------------------------------------------------------
package fhls_pkg;

    // default sizes of the history store
    localparam int HISTORY_FRAMES_DEF   = 32;
    localparam int FRAME_PIXELS_MAX_DEF = 4096;

    // pixel and bus widths
    localparam int PIX_W      = 8;
    localparam int TDATA_W    = 3 * PIX_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OPACITY      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HISTORY_LEN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PIXELS = 3'd4;

    // compare modes
    localparam logic [1:0] MODE_LUMA_MIN    = 2'd0;
    localparam logic [1:0] MODE_LUMA_MAX    = 2'd1;
    localparam logic [1:0] MODE_WEIGHT_LESS = 2'd2;
    localparam logic [1:0] MODE_WEIGHT_MORE = 2'd3;

    // register reset values
    localparam logic [1:0]            COMPARE_MODE_RST = MODE_LUMA_MAX;
    localparam logic [PIX_W-1:0]      OPACITY_RST      = 8'd150;
    localparam logic [4:0]            HISTORY_LEN_RST  = 5'd8;
    localparam logic                  WRAP_RST         = 1'b1;
    localparam logic [CFG_DATA_W-1:0] FRAME_PIXELS_RST = 13'd4096;

    localparam logic [PIX_W-1:0] LUMA_FULL = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] y;
    } pixel_t;

    // black: Y 0, Cb 128, Cr 128
    localparam pixel_t PIXEL_BLACK = '{cr: 8'd128, cb: 8'd128, y: 8'd0};

endpackage

FILE: rtl/frame_history_luma_scratcher.sv
// ----------------------------------------------------------------------------
// frame_history_luma_scratcher
// keeps a ring of past frames and mixes each pixel with its stored history
// ----------------------------------------------------------------------------
// Takes one YCbCr pixel per clock in raster order and returns one pixel per
// clock while the output is not stalled. Each pixel is compared in luma
// with the same pixel of the current history slot; the winner is written to
// the next slot and sent out, or in backward playback the stored pixel of
// that slot is sent out. The history lives in two single-port-write block
// memories (slot zero, and the remaining slots), each read once per pixel;
// one read and one write per memory per cycle is what sets the rate of one
// pixel per clock. After reset the block sweeps both memories to black, one
// entry per cycle, through every entry of the larger memory; s_tready stays low
// during that sweep while configuration writes are taken as usual. Frame length,
// history length and wrap mode are sampled at the first pixel of each frame;
// compare mode and opacity apply from the next pixel on. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module frame_history_luma_scratcher
    import fhls_pkg::*;
#(
    parameter int HISTORY_FRAMES   = HISTORY_FRAMES_DEF,
    parameter int FRAME_PIXELS_MAX = FRAME_PIXELS_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,      // luma, chroma_blue, chroma_red
    // result pixel stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,      // out_luma, out_chroma_blue, out_chroma_red
    output logic                  m_tlast,      // frame_end
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SW = $clog2(HISTORY_FRAMES);
    localparam int NW = $clog2(HISTORY_FRAMES + 1);
    localparam int PW = (FRAME_PIXELS_MAX > 1) ? $clog2(FRAME_PIXELS_MAX) : 1;
    localparam int LW = $clog2(FRAME_PIXELS_MAX + 1);
    localparam int REST_DEPTH = (HISTORY_FRAMES - 1) * FRAME_PIXELS_MAX;
    localparam int RW = (REST_DEPTH > 1) ? $clog2(REST_DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]       compare_mode_reg;
    logic [PIX_W-1:0] opacity_reg;
    logic [4:0]       history_len_reg;
    logic             wrap_reg;
    logic [12:0]      frame_pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_mode_reg <= COMPARE_MODE_RST;
            opacity_reg      <= OPACITY_RST;
            history_len_reg  <= HISTORY_LEN_RST;
            wrap_reg         <= WRAP_RST;
            frame_pixels_reg <= FRAME_PIXELS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_COMPARE_MODE: compare_mode_reg <= cfg_wr_data[1:0];
                REG_OPACITY:      opacity_reg      <= cfg_wr_data[PIX_W-1:0];
                REG_HISTORY_LEN:  history_len_reg  <= cfg_wr_data[4:0];
                REG_WRAP:         wrap_reg         <= cfg_wr_data[0];
                REG_FRAME_PIXELS: frame_pixels_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // clearing sweep after reset
    // ------------------------------------------------------------------
    logic          clearing_reg;
    logic [RW-1:0] clr_cnt_reg;
    logic          clr_bank0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (32'(clr_cnt_reg) == REST_DEPTH - 1) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // slot zero is shorter, so only the first part of the sweep touches it
    assign clr_bank0 = clearing_reg && (32'(clr_cnt_reg) < FRAME_PIXELS_MAX);

    // ------------------------------------------------------------------
    // pipeline handshake: the whole pipe moves when the output can take data
    // ------------------------------------------------------------------
    logic   advance;
    logic   accept;
    logic   m_tvalid_reg;
    pixel_t in_pix;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance && !clearing_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_pix   = s_tdata;

    // ------------------------------------------------------------------
    // frame and slot sequencing
    // ------------------------------------------------------------------
    logic [PW-1:0] pos_reg;
    logic [SW-1:0] slot_index_reg;
    logic          backward_reg;
    logic          prev_wrap_reg;
    logic [LW-1:0] frame_len_reg;
    logic [SW-1:0] cmp_slot_reg;
    logic [SW-1:0] store_slot_reg;
    logic          refresh_reg;
    logic          bwd_out_reg;

    logic [LW-1:0] len_sat;
    logic [NW:0]   n_sat;
    logic [NW:0]   si0;
    logic [NW:0]   si1;
    logic          fs_refresh;
    logic          fs_back;
    logic          frame_start;

    always_comb begin
        // frame length, zero taken as one, capped to the store
        if (frame_pixels_reg == '0) begin
            len_sat = LW'(1);
        end else if (32'(frame_pixels_reg) > FRAME_PIXELS_MAX) begin
            len_sat = LW'(FRAME_PIXELS_MAX);
        end else begin
            len_sat = LW'(frame_pixels_reg);
        end
        // history length, zero taken as one, capped to the slots
        if (history_len_reg == '0) begin
            n_sat = (NW+1)'(1);
        end else if (32'(history_len_reg) > HISTORY_FRAMES) begin
            n_sat = (NW+1)'(HISTORY_FRAMES);
        end else begin
            n_sat = (NW+1)'(history_len_reg);
        end
        // a toggled wrap setting restarts at the top of the ring
        si0 = (wrap_reg != prev_wrap_reg) ? n_sat : (NW+1)'(slot_index_reg);
        fs_refresh = (si0 == '0);
        fs_back = backward_reg;
        if (backward_reg) begin
            si1 = (si0 != '0) ? si0 - 1'b1 : si0;
        end else begin
            si1 = si0 + 1'b1;
        end
        if (si1 >= n_sat) begin
            if (!wrap_reg) begin
                fs_back = 1'b1;
                si1     = n_sat - 1'b1;
            end else begin
                si1 = '0;
            end
        end
        if (si1 == '0) begin
            fs_back = 1'b0;
        end
    end

    assign frame_start = (pos_reg == '0);

    // per-pixel view of the frame settings
    logic [LW-1:0] cur_len;
    logic [SW-1:0] cur_cmp;
    logic [SW-1:0] cur_store;
    logic          cur_refresh;
    logic          cur_bwd;
    logic          cur_last;
    logic [SW-1:0] rd_slot;

    assign cur_len     = frame_start ? len_sat    : frame_len_reg;
    assign cur_cmp     = frame_start ? slot_index_reg : cmp_slot_reg;
    assign cur_store   = frame_start ? SW'(si1)   : store_slot_reg;
    assign cur_refresh = frame_start ? fs_refresh : refresh_reg;
    assign cur_bwd     = frame_start ? fs_back    : bwd_out_reg;
    assign cur_last    = (32'(pos_reg) + 1 >= 32'(cur_len));
    // backward playback reads the slot it shows, otherwise the compare slot
    assign rd_slot     = cur_bwd ? cur_store : cur_cmp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            slot_index_reg <= '0;
            backward_reg   <= 1'b0;
            prev_wrap_reg  <= 1'b0;
            frame_len_reg  <= '0;
            cmp_slot_reg   <= '0;
            store_slot_reg <= '0;
            refresh_reg    <= 1'b0;
            bwd_out_reg    <= 1'b0;
        end else if (accept) begin
            pos_reg <= cur_last ? '0 : pos_reg + 1'b1;
            if (frame_start) begin
                frame_len_reg  <= len_sat;
                cmp_slot_reg   <= slot_index_reg;
                store_slot_reg <= SW'(si1);
                refresh_reg    <= fs_refresh;
                bwd_out_reg    <= fs_back;
                slot_index_reg <= SW'(si1);
                backward_reg   <= fs_back;
                prev_wrap_reg  <= wrap_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: memory data back, compare, write back
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    logic [PW-1:0] s1_pos_reg;
    logic [SW-1:0] s1_store_reg;
    logic [RW-1:0] s1_rest_waddr_reg;
    logic          s1_refresh_reg;
    logic          s1_bwd_reg;
    logic          s1_rd_zero_reg;
    logic          s1_fwd_reg;
    pixel_t        s1_fwd_pix_reg;
    logic          s1_last_reg;

    logic [RW-1:0] rd_rest_addr;
    logic [RW-1:0] store_rest_addr;
    logic          s1_we0;
    logic          s1_wer;
    logic          fwd_hit;
    pixel_t        result;

    // slots 1 and up share one memory at a fixed stride
    assign rd_rest_addr    = RW'(32'(rd_slot - 1'b1) * FRAME_PIXELS_MAX + 32'(pos_reg));
    assign store_rest_addr = RW'(32'(cur_store - 1'b1) * FRAME_PIXELS_MAX + 32'(pos_reg));

    // slot zero takes the refresh write and any store write aimed at it
    assign s1_we0 = s1_valid_reg && (s1_refresh_reg || (!s1_bwd_reg && s1_store_reg == '0));
    assign s1_wer = s1_valid_reg && !s1_bwd_reg && (s1_store_reg != '0);

    // the entry read now is being written by the pixel ahead (one-pixel frames)
    assign fwd_hit = (pos_reg == s1_pos_reg) &&
                     ((rd_slot == '0) ? s1_we0 : (s1_wer && rd_slot == s1_store_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg        <= in_pix;
            s1_pos_reg        <= pos_reg;
            s1_store_reg      <= cur_store;
            s1_rest_waddr_reg <= store_rest_addr;
            s1_refresh_reg    <= cur_refresh;
            s1_bwd_reg        <= cur_bwd;
            s1_rd_zero_reg    <= (rd_slot == '0);
            s1_fwd_reg        <= fwd_hit;
            s1_fwd_pix_reg    <= result;
            s1_last_reg       <= cur_last;
        end
    end

    // ------------------------------------------------------------------
    // history memories
    // ------------------------------------------------------------------
    pixel_t        bank0_mem [FRAME_PIXELS_MAX];
    pixel_t        rest_mem  [REST_DEPTH];
    pixel_t        bank0_rdata_reg;
    pixel_t        rest_rdata_reg;
    logic          bank0_we;
    logic [PW-1:0] bank0_waddr;
    pixel_t        bank0_wdata;
    logic          rest_we;
    logic [RW-1:0] rest_waddr;
    pixel_t        rest_wdata;

    assign bank0_we    = clr_bank0 || (advance && s1_we0);
    assign bank0_waddr = clearing_reg ? clr_cnt_reg[PW-1:0] : s1_pos_reg;
    assign bank0_wdata = clearing_reg ? PIXEL_BLACK : result;
    assign rest_we     = clearing_reg || (advance && s1_wer);
    assign rest_waddr  = clearing_reg ? clr_cnt_reg : s1_rest_waddr_reg;
    assign rest_wdata  = clearing_reg ? PIXEL_BLACK : result;

    always_ff @(posedge aclk) begin
        if (bank0_we) begin
            bank0_mem[bank0_waddr] <= bank0_wdata;
        end
        if (advance) begin
            bank0_rdata_reg <= bank0_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (rest_we) begin
            rest_mem[rest_waddr] <= rest_wdata;
        end
        if (advance) begin
            rest_rdata_reg <= rest_mem[rd_rest_addr];
        end
    end

    // ------------------------------------------------------------------
    // luma compare and select
    // ------------------------------------------------------------------
    pixel_t               stored;
    pixel_t               chosen;
    logic [2*PIX_W-1:0]   prod_stored;
    logic [2*PIX_W-1:0]   prod_in;
    logic                 take;

    always_comb begin
        if (s1_fwd_reg) begin
            stored = s1_fwd_pix_reg;
        end else if (s1_rd_zero_reg) begin
            stored = bank0_rdata_reg;
        end else begin
            stored = rest_rdata_reg;
        end
        prod_stored = (2*PIX_W)'(stored.y) * (2*PIX_W)'(opacity_reg);
        prod_in     = (2*PIX_W)'(s1_pix_reg.y) * (2*PIX_W)'(LUMA_FULL - opacity_reg);
        case (compare_mode_reg)
            MODE_LUMA_MIN:    take = stored.y < s1_pix_reg.y;
            MODE_LUMA_MAX:    take = stored.y > s1_pix_reg.y;
            MODE_WEIGHT_LESS: take = prod_stored < prod_in;
            default:          take = prod_stored > prod_in;
        endcase
        // a refreshed slot zero holds the input itself, so either choice is the input
        if (s1_refresh_reg || !take) begin
            chosen = s1_pix_reg;
        end else begin
            chosen = stored;
        end
        result = s1_bwd_reg ? stored : chosen;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    pixel_t m_pix_reg;
    logic   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_pix_reg  <= result;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/fhls_checker.sv
// ----------------------------------------------------------------------------
// fhls_checker
// port-level checks for the frame history luma scratcher
// ----------------------------------------------------------------------------
module fhls_checker
    import fhls_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a blocked output blocks the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output blocked");

    // the clearing sweep holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input ready before history was cleared");

endmodule

bind frame_history_luma_scratcher fhls_checker u_fhls_checker (.*);

FILE: test/frame_history_luma_scratcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_history_luma_scratcher_test
// self-checking bench for the frame history luma scratcher
// ----------------------------------------------------------------------------
// Streams YCbCr pixels through the block and checks every result transfer
// against an in-bench model of the history ring. The model covers the compare
// modes, opacity weighting, slot cycling with wrap or ping-pong, slot zero
// refresh and backward playback. A short table of directed pixels and register
// writes runs first, then random phases with random register settings and
// mostly small frames. Both stream sides stall at random, except for one
// phase that runs with no idling at all, and registers are only written once
// all results are back.
// ----------------------------------------------------------------------------
module frame_history_luma_scratcher_test;
    import fhls_pkg::*;

    localparam int HIST_SLOTS = HISTORY_FRAMES_DEF;
    localparam int FRAME_MAX  = FRAME_PIXELS_MAX_DEF;
    localparam int N_DIRECTED = 31;

    // one pixel of output plus its end-of-frame flag
    typedef struct packed {
        pixel_t pix;
        logic   last;
    } scratch_result_t;

    // directed table: either a register write or a pixel transfer
    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        pixel_t                pix;       // hex cr, cb, y
        logic                  known;     // result typed in below
        pixel_t                want;
        logic                  want_last;
    } step_row_t;

    localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // one-pixel frames, one history slot: zero sizes saturate to one
        '{ROW_REG, REG_FRAME_PIXELS, 13'd0, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_HISTORY_LEN, 13'd0, 24'h0, 1'b0, 24'h0, 1'b0},
        // reset mode is luma max against a black store, so the input passes
        '{ROW_PIXEL, '0, '0, 24'hFF00FF, 1'b1, 24'hFF00FF, 1'b1},
        // slot zero refreshed from the input before the compare
        '{ROW_PIXEL, '0, '0, 24'h00FF00, 1'b1, 24'h00FF00, 1'b1},
        '{ROW_PIXEL, '0, '0, 24'h808080, 1'b1, 24'h808080, 1'b1},
        // luma min over the longest history, two-pixel frames
        '{ROW_REG, REG_COMPARE_MODE, 13'(MODE_LUMA_MIN), 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_HISTORY_LEN, 13'd31, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_FRAME_PIXELS, 13'd2, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h1410C8, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h281E32, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h020164, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h040300, 1'b0, 24'h0, 1'b0},
        // weighted less with no weight on the stored luma
        '{ROW_REG, REG_COMPARE_MODE, 13'(MODE_WEIGHT_LESS), 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_OPACITY, 13'd0, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h10207F, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'hFFFF01, 1'b0, 24'h0, 1'b0},
        // weighted greater with full weight on the stored luma
        '{ROW_REG, REG_COMPARE_MODE, 13'(MODE_WEIGHT_MORE), 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_OPACITY, 13'd255, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'hA5A5FE, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h5A5A00, 1'b0, 24'h0, 1'b0},
        // ping-pong over two slots, wrap change restarts at slot n
        '{ROW_REG, REG_OPACITY, 13'd128, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_COMPARE_MODE, 13'(MODE_LUMA_MAX), 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_WRAP, 13'd0, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_HISTORY_LEN, 13'd2, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_REG, REG_FRAME_PIXELS, 13'd1, 24'h0, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h112233, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h445566, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h778899, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'hAABBCC, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'hDDEEFF, 1'b0, 24'h0, 1'b0},
        '{ROW_PIXEL, '0, '0, 24'h0000FF, 1'b0, 24'h0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // clock, reset and block ports, all known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    always #4 aclk = ~aclk;

    frame_history_luma_scratcher u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // history ring model: registers, slot state and the pixel store
    // ------------------------------------------------------------------------
    logic [1:0]            cfg_mode         = COMPARE_MODE_RST;
    logic [PIX_W-1:0]      cfg_opacity      = OPACITY_RST;
    logic [4:0]            cfg_hist_len     = HISTORY_LEN_RST;
    logic                  cfg_wrap         = WRAP_RST;
    logic [CFG_DATA_W-1:0] cfg_frame_pixels = FRAME_PIXELS_RST;

    int unsigned slot_idx      = 0;
    bit          backward      = 1'b0;
    bit          last_wrap     = 1'b0;
    int unsigned frame_pos     = 0;
    // latched at frame start
    int unsigned frame_len     = 0;
    int unsigned cmp_slot      = 0;
    int unsigned write_slot    = 0;
    bit          refresh_slot0 = 1'b0;
    bit          show_stored   = 1'b0;

    pixel_t history_mem [HIST_SLOTS*FRAME_MAX];

    scratch_result_t expected_pixels [$];

    int unsigned mismatches      = 0;
    int unsigned pixels_sent     = 0;
    int unsigned random_pixels   = 0;
    int unsigned frames_out      = 0;
    int unsigned backward_frames = 0;
    int unsigned phases          = 0;
    bit          no_stalls       = 1'b0;

    function automatic int unsigned store_addr(input int unsigned slot, input int unsigned pos);
        return ((slot >= HIST_SLOTS) ? HIST_SLOTS - 1 : slot) * FRAME_MAX + pos;
    endfunction

    // one pixel through the ring: compare, pick, store or play back
    function automatic scratch_result_t scratch_pixel(input pixel_t pix_in);
        int unsigned     n;
        int unsigned     sy;
        int unsigned     iy;
        int unsigned     op;
        bit              take;
        pixel_t          stored;
        pixel_t          pick;
        scratch_result_t res;

        if (frame_pos == 0 || frame_pos >= frame_len) begin
            // frame start: sizes, compare slot, wrap restart, slot advance
            frame_pos = 0;
            if (cfg_frame_pixels == 0)
                frame_len = 1;
            else if (cfg_frame_pixels > FRAME_MAX)
                frame_len = FRAME_MAX;
            else
                frame_len = cfg_frame_pixels;
            n = (cfg_hist_len == 0) ? 1 : cfg_hist_len;
            if (n > HIST_SLOTS)
                n = HIST_SLOTS;
            cmp_slot = slot_idx;
            if (cfg_wrap != last_wrap) begin
                last_wrap = cfg_wrap;
                slot_idx  = n;
            end
            refresh_slot0 = (slot_idx == 0);
            if (backward) begin
                if (slot_idx > 0)
                    slot_idx--;
            end else begin
                slot_idx++;
            end
            if (slot_idx >= n) begin
                if (!cfg_wrap) begin
                    backward = 1'b1;
                    slot_idx = n - 1;
                end else begin
                    slot_idx = 0;
                end
            end
            if (slot_idx == 0)
                backward = 1'b0;
            write_slot  = slot_idx;
            show_stored = backward;
            if (show_stored)
                backward_frames++;
        end

        if (refresh_slot0)
            history_mem[store_addr(0, frame_pos)] = pix_in;

        stored = history_mem[store_addr(cmp_slot, frame_pos)];
        sy = stored.y;
        iy = pix_in.y;
        op = cfg_opacity;
        case (cfg_mode)
            MODE_LUMA_MIN:    take = (sy < iy);
            MODE_LUMA_MAX:    take = (sy > iy);
            MODE_WEIGHT_LESS: take = (sy * op < iy * (LUMA_FULL - op));
            default:          take = (sy * op > iy * (LUMA_FULL - op));
        endcase
        pick = take ? stored : pix_in;

        // backward playback shows the next slot and leaves it untouched
        if (show_stored)
            pick = history_mem[store_addr(write_slot, frame_pos)];
        else
            history_mem[store_addr(write_slot, frame_pos)] = pick;

        frame_pos++;
        res.pix  = pick;
        res.last = (frame_pos >= frame_len);
        if (res.last)
            frame_pos = 0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one transfer on the input side; valid stays high into the next call
    task automatic send_pixel(input pixel_t pix);
        if (!no_stalls && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 34);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        expected_pixels.push_back(scratch_pixel(pix));
    endtask

    // stop sending and let every outstanding result come back
    task automatic await_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    // register write, mirrored into the model with the register widths
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_COMPARE_MODE: cfg_mode         = value[1:0];
            REG_OPACITY:      cfg_opacity      = value[PIX_W-1:0];
            REG_HISTORY_LEN:  cfg_hist_len     = value[4:0];
            REG_WRAP:         cfg_wrap         = value[0];
            REG_FRAME_PIXELS: cfg_frame_pixels = value;
            default: ;
        endcase
    endtask

    task automatic count_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
            count_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, then compare each transfer in order
    // ------------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= no_stalls || ($urandom_range(99) >= 34);

    always @(posedge aclk) begin : result_check
        scratch_result_t want;
        pixel_t          got;

        if (aresetn && m_tvalid && m_tready) begin
            got = pixel_t'(m_tdata);
            if (expected_pixels.size() == 0) begin
                count_mismatch($sformatf("result %06h with nothing pending", m_tdata));
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_luma", want.pix.y, got.y);
                check_field("out_chroma_blue", want.pix.cb, got.cb);
                check_field("out_chroma_red", want.pix.cr, got.cr);
                check_field("frame_end", 8'(want.last), 8'(m_tlast));
            end
            if (m_tlast === 1'b1)
                frames_out++;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        pixel_t           pix;
        step_row_t        row;
        int unsigned      phase_len;
        logic [PIX_W-1:0] op;

        // store comes out of reset black
        foreach (history_mem[i])
            history_mem[i] = PIXEL_BLACK;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; the block is still sweeping its store here
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG) begin
                await_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_pixel(row.pix);
                if (row.known)
                    expected_pixels[$] = '{pix: row.want, last: row.want_last};
            end
        end

        // random phases; registers change between phases, often mid-frame
        while (pixels_sent < 1200) begin
            await_idle();
            if (phases == 0 || $urandom_range(1))
                write_reg(REG_COMPARE_MODE, CFG_DATA_W'($urandom));
            if (phases == 0 || $urandom_range(1)) begin
                case ($urandom_range(3))
                    0:       op = '0;
                    1:       op = LUMA_FULL;
                    default: op = PIX_W'($urandom);
                endcase
                write_reg(REG_OPACITY, {5'($urandom), op});
            end
            // short histories turn around often
            if (phases == 0 || $urandom_range(1))
                write_reg(REG_HISTORY_LEN, {8'($urandom),
                          ($urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom))});
            if (phases == 0 || $urandom_range(1))
                write_reg(REG_WRAP, CFG_DATA_W'($urandom));
            // small frames keep history cycling cheap
            if (phases == 0 || $urandom_range(2) == 0)
                write_reg(REG_FRAME_PIXELS, ($urandom_range(3) == 0) ?
                          CFG_DATA_W'($urandom_range(40)) : CFG_DATA_W'($urandom_range(6)));
            phases++;
            // one long phase with no idling on either side
            no_stalls = (phases == 3);
            phase_len = no_stalls ? 200 : $urandom_range(20, 120);
            repeat (phase_len) begin
                pix = pixel_t'($urandom);
                case ($urandom_range(7))
                    0: pix.y = '0;
                    1: pix.y = LUMA_FULL;
                    default: ;
                endcase
                send_pixel(pix);
                random_pixels++;
            end
            no_stalls = 1'b0;
        end

        // final drain with a bound, then a last wait for stray transfers
        s_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && expected_pixels.size() != 0; i++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_pixels.size() != 0)
            count_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

        $display("%0d pixels over %0d result frames, %0d frames in backward playback",
                 pixels_sent, frames_out, backward_frames);
        $display("%0d random pixels in %0d register phases after the directed rows",
                 random_pixels, phases);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop, far beyond the store sweep plus the slowest stalled run
    initial begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
